@@ hdl/drs_pkg.sv @@
// Shared types, widths and constants for the date range seconds block.
// No dependencies; imported by every module of the block.
package drs_pkg;

  // Field widths
  localparam int unsigned YEAR_W  = 16;
  localparam int unsigned MONTH_W = 4;
  localparam int unsigned DAY_W   = 8;
  localparam int unsigned SEC_W   = 41;

  // Day number of a date fits in 25 bits (year 65535, month 13, day 255)
  localparam int unsigned DAYS_W  = 25;
  // Day of year before the day is added (at most 366)
  localparam int unsigned DOY_W   = 9;

  // Division by 100 through a reciprocal: q = (x * RECIP100) >> RECIP_SHIFT,
  // exact for x below 91180, which covers every operand here (at most 65634)
  localparam int unsigned OPND_W      = YEAR_W + 1;
  localparam int unsigned PROD_W      = 2 * OPND_W;
  localparam int unsigned RECIP_SHIFT = 23;
  localparam int unsigned QUOT_W      = PROD_W - RECIP_SHIFT;
  localparam logic [OPND_W-1:0] RECIP100 = OPND_W'(83887);

  localparam logic [YEAR_W-1:0] CENTURY   = YEAR_W'(100);
  localparam logic [OPND_W-1:0] ROUND4    = OPND_W'(3);
  localparam logic [OPND_W-1:0] ROUND100  = OPND_W'(99);
  localparam logic [OPND_W-1:0] ROUND400  = OPND_W'(399);
  localparam logic [DAYS_W-1:0] DAYS_YEAR = DAYS_W'(365);

  // Seconds per day
  localparam int unsigned SPD_W = 17;
  localparam logic [SPD_W-1:0] SEC_PER_DAY = SPD_W'(86400);

  // Month codes
  localparam logic [MONTH_W-1:0] MONTH_MAR = MONTH_W'(3);
  localparam logic [MONTH_W-1:0] MONTH_BAD = MONTH_W'(14);

  // Pipeline depth from request to result
  localparam int unsigned LATENCY = 4;

  // Control that travels with each request
  typedef struct packed {
    logic valid;
    logic err;
  } ctl_t;

  // Days in the months before the given one, common year
  function automatic logic [DOY_W-1:0] cum_days(input logic [MONTH_W-1:0] month);
    logic [DOY_W-1:0] res;
    case (month)
      4'd2:    res = DOY_W'(31);
      4'd3:    res = DOY_W'(59);
      4'd4:    res = DOY_W'(90);
      4'd5:    res = DOY_W'(120);
      4'd6:    res = DOY_W'(151);
      4'd7:    res = DOY_W'(181);
      4'd8:    res = DOY_W'(212);
      4'd9:    res = DOY_W'(243);
      4'd10:   res = DOY_W'(273);
      4'd11:   res = DOY_W'(304);
      4'd12:   res = DOY_W'(334);
      4'd13:   res = DOY_W'(365);
      default: res = '0;
    endcase
    return res;
  endfunction

endpackage

@@ hdl/drs_day_num.sv @@
// Two-stage day number unit: days from the start of year 0 to a given date.
// Depends on drs_pkg.
module drs_day_num import drs_pkg::*; (
  input  logic               clk_i,
  input  logic [YEAR_W-1:0]  year_i,
  input  logic [MONTH_W-1:0] month_i,
  input  logic [DAY_W-1:0]   day_i,
  output logic [DAYS_W-1:0]  days_o
);

  // Stage A: reciprocal products for the century and 400-year counts
  logic [OPND_W-1:0]  y_ext, y99, y399, y399s;
  logic [YEAR_W-1:0]  year_q;
  logic [MONTH_W-1:0] month_q;
  logic [DAY_W-1:0]   day_q;
  logic [PROD_W-1:0]  py_d, py_q, p99_d, p99_q, p400_d, p400_q;

  assign y_ext  = {1'b0, year_i};
  assign y99    = y_ext + ROUND100;
  assign y399   = y_ext + ROUND400;
  assign y399s  = y399 >> 2;
  assign py_d   = PROD_W'(y_ext) * PROD_W'(RECIP100);
  assign p99_d  = PROD_W'(y99) * PROD_W'(RECIP100);
  assign p400_d = PROD_W'(y399s) * PROD_W'(RECIP100);

  always_ff @(posedge clk_i) begin
    year_q  <= year_i;
    month_q <= month_i;
    day_q   <= day_i;
    py_q    <= py_d;
    p99_q   <= p99_d;
    p400_q  <= p400_d;
  end

  // Stage B: leap test, leap days before the year, day of year, day number
  logic [QUOT_W-1:0] q_y, q99, q400;
  logic              is_cent, leap;
  logic [OPND_W-1:0] y3;
  logic [DAYS_W-1:0] leaps, doy, days_d, days_q;

  assign q_y  = py_q[RECIP_SHIFT +: QUOT_W];
  assign q99  = p99_q[RECIP_SHIFT +: QUOT_W];
  assign q400 = p400_q[RECIP_SHIFT +: QUOT_W];

  assign is_cent = ((YEAR_W'(q_y) * CENTURY) == year_q);
  assign leap    = ((year_q[1:0] == 2'b00) && !is_cent) ||
                   (is_cent && (q_y[1:0] == 2'b00));

  assign y3     = ({1'b0, year_q} + ROUND4) >> 2;
  assign leaps  = DAYS_W'(y3) - DAYS_W'(q99) + DAYS_W'(q400);
  assign doy    = DAYS_W'(cum_days(month_q))
                + DAYS_W'(leap && (month_q >= MONTH_MAR))
                + DAYS_W'(day_q);
  assign days_d = DAYS_W'(year_q) * DAYS_YEAR + leaps + doy;

  always_ff @(posedge clk_i) begin
    days_q <= days_d;
  end

  assign days_o = days_q;

endmodule

@@ hdl/drs_dist.sv @@
// Two-stage distance unit: absolute day difference, then scaling to seconds.
// Depends on drs_pkg.
module drs_dist import drs_pkg::*; (
  input  logic              clk_i,
  input  logic [DAYS_W-1:0] days_a_i,
  input  logic [DAYS_W-1:0] days_b_i,
  output logic [SEC_W-1:0]  seconds_o
);

  localparam int unsigned MUL_W = DAYS_W + SPD_W;

  // Stage C: absolute difference of the day numbers
  logic [DAYS_W-1:0] diff_d, diff_q;

  assign diff_d = (days_a_i > days_b_i) ? (days_a_i - days_b_i)
                                        : (days_b_i - days_a_i);

  always_ff @(posedge clk_i) begin
    diff_q <= diff_d;
  end

  // Stage D: days to seconds, kept to the result width
  logic [MUL_W-1:0] prod;
  logic [SEC_W-1:0] sec_q;

  assign prod = MUL_W'(diff_q) * MUL_W'(SEC_PER_DAY);

  always_ff @(posedge clk_i) begin
    sec_q <= prod[SEC_W-1:0];
  end

  assign seconds_o = sec_q;

endmodule

@@ hdl/date_range_seconds.sv @@
// Distance in seconds between two Gregorian dates; pipelined, one request per clock.
// One request is taken on every clock with start high; busy never rises.
// The result of each request appears for one cycle with done_o high, after the four
// register stages (reciprocal products, day numbers, day difference, scaling by
// 86400). Results cannot be stalled, so the receiver must take each one in the
// cycle it is shown. A month of 14 or more in either date gives range_error_o = 1
// and zero seconds.
// Depends on drs_pkg, drs_day_num and drs_dist.
module date_range_seconds import drs_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [YEAR_W-1:0]  start_year_i,
  input  logic [MONTH_W-1:0] start_month_i,
  input  logic [DAY_W-1:0]   start_day_i,
  input  logic [YEAR_W-1:0]  end_year_i,
  input  logic [MONTH_W-1:0] end_month_i,
  input  logic [DAY_W-1:0]   end_day_i,
  output logic               done_o,
  output logic [SEC_W-1:0]   seconds_between_o,
  output logic               range_error_o
);

  // Never stalls
  assign busy = 1'b0;

  // Control pipeline: valid and error flags follow the data
  ctl_t ctl_d;
  ctl_t ctl_q [LATENCY];

  assign ctl_d.valid = start;
  assign ctl_d.err   = (start_month_i >= MONTH_BAD) || (end_month_i >= MONTH_BAD);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < LATENCY; i++) ctl_q[i] <= '0;
    end else begin
      ctl_q[0] <= ctl_d;
      for (int i = 1; i < LATENCY; i++) ctl_q[i] <= ctl_q[i-1];
    end
  end

  // Day numbers of both dates
  logic [DAYS_W-1:0] days_a, days_b;

  drs_day_num u_day_a (
    .clk_i   (clk_i),
    .year_i  (start_year_i),
    .month_i (start_month_i),
    .day_i   (start_day_i),
    .days_o  (days_a)
  );

  drs_day_num u_day_b (
    .clk_i   (clk_i),
    .year_i  (end_year_i),
    .month_i (end_month_i),
    .day_i   (end_day_i),
    .days_o  (days_b)
  );

  // Distance in seconds
  logic [SEC_W-1:0] seconds;

  drs_dist u_dist (
    .clk_i     (clk_i),
    .days_a_i  (days_a),
    .days_b_i  (days_b),
    .seconds_o (seconds)
  );

  // Result: zero seconds on error
  assign done_o            = ctl_q[LATENCY-1].valid;
  assign range_error_o     = ctl_q[LATENCY-1].valid && ctl_q[LATENCY-1].err;
  assign seconds_between_o = ctl_q[LATENCY-1].err ? '0 : seconds;

endmodule

@@ hdl/drs_checker.sv @@
// Port-level checks for date_range_seconds, bound to the top level.
// Depends on drs_pkg.
module drs_checker import drs_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             start,
  input logic             busy,
  input logic             done_o,
  input logic [SEC_W-1:0] seconds_between_o,
  input logic             range_error_o
);

  // Every request comes back after the fixed latency
  a_req_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##LATENCY done_o)
    else $error("request did not produce a result on time");

  // No result without a request
  a_done_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy, LATENCY))
    else $error("result without a matching request");

  // Error result carries zero seconds
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    range_error_o |-> (seconds_between_o == '0))
    else $error("error result with nonzero seconds");

  // Error flag only with a result
  a_err_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    range_error_o |-> done_o)
    else $error("error flag without result strobe");

endmodule

bind date_range_seconds drs_checker u_drs_checker (.*);
